[hdl/pese_pkg.sv]
package pese_pkg;

  localparam int DefStackDepth = 128;
  localparam int DataW = 32;

  localparam logic [7:0] SymPlus  = 8'h2B;
  localparam logic [7:0] SymMinus = 8'h2D;
  localparam logic [7:0] SymMul   = 8'h2A;
  localparam logic [7:0] SymDiv   = 8'h2F;
  localparam logic [7:0] SymMod   = 8'h25;
  localparam logic [7:0] SymPow   = 8'h5E;
  localparam logic [7:0] SymZero  = 8'h30;
  localparam logic [7:0] SymNine  = 8'h39;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_OVERFLOW = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_DIVZERO  = 3'd3,
    ST_UNKNOWN  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_POW
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RDA, S_RDB, S_WAITB, S_EXEC, S_ITER, S_WRITE, S_RDTOP, S_TOPW, S_OUT
  } state_t;

  typedef struct packed {
    logic    load_a;
    logic    load_b;
    logic    load_top;
    logic    start_iter;
    logic    step_iter;
    logic    exec_simple;
  } dp_cmd_t;

  typedef struct packed {
    logic b_zero;
    logic iter_done;
  } dp_sts_t;

endpackage

[hdl/pese_ram.sv]
module pese_ram #(
  parameter int Width = 32,
  parameter int Depth = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[hdl/pese_datapath.sv]
module pese_datapath (
  input  logic                   clk,
  input  pese_pkg::op_t          op,
  input  pese_pkg::dp_cmd_t      cmd,
  input  logic [31:0]            rdata,
  output pese_pkg::dp_sts_t      sts,
  output logic [31:0]            result,
  output logic [31:0]            top
);
  import pese_pkg::*;

  logic [31:0] a_r, b_r, res_r, top_r;
  logic [31:0] rem_r, quo_r, dvs_r, base_r, exp_r;
  logic        qneg_r, rneg_r;
  logic [5:0]  cnt_r;
  logic [31:0] mag_a, mag_b;
  logic [32:0] trial;
  logic [31:0] rem_sh;
  logic [31:0] mul_p, sq_p;

  assign mag_a = a_r[31] ? (~a_r + 32'd1) : a_r;
  assign mag_b = b_r[31] ? (~b_r + 32'd1) : b_r;
  assign rem_sh = {rem_r[30:0], quo_r[31]};
  assign trial = {1'b0, rem_sh} - {1'b0, dvs_r};
  assign mul_p = res_r * base_r;
  assign sq_p = base_r * base_r;

  assign sts.b_zero = (b_r == 32'd0);
  assign sts.iter_done = (op == OP_POW) ? (exp_r == 32'd0) : (cnt_r == 6'd32);

  always_ff @(posedge clk) begin
    if (cmd.load_a) begin
      a_r <= rdata;
    end
    if (cmd.load_b) begin
      b_r <= rdata;
    end
    if (cmd.load_top) begin
      top_r <= rdata;
    end
    if (cmd.exec_simple) begin
      unique case (op)
        OP_ADD:  res_r <= a_r + b_r;
        OP_SUB:  res_r <= a_r - b_r;
        OP_MUL:  res_r <= a_r * b_r;
        default: res_r <= 32'd1;
      endcase
    end
    if (cmd.start_iter) begin
      cnt_r <= 6'd0;
      rem_r <= 32'd0;
      quo_r <= mag_a;
      dvs_r <= mag_b;
      qneg_r <= a_r[31] ^ b_r[31];
      rneg_r <= a_r[31];
      base_r <= a_r;
      exp_r <= b_r[31] ? 32'd0 : b_r;
      res_r <= 32'd1;
    end else if (cmd.step_iter) begin
      if (op == OP_POW) begin
        if (exp_r[0]) begin
          res_r <= mul_p;
        end
        base_r <= sq_p;
        exp_r <= {1'b0, exp_r[31:1]};
      end else begin
        cnt_r <= cnt_r + 6'd1;
        if (!trial[32]) begin
          rem_r <= trial[31:0];
          quo_r <= {quo_r[30:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          quo_r <= {quo_r[30:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    unique case (op)
      OP_DIV:  result = qneg_r ? (~quo_r + 32'd1) : quo_r;
      OP_MOD:  result = rneg_r ? (~rem_r + 32'd1) : rem_r;
      default: result = res_r;
    endcase
  end

  assign top = top_r;
endmodule

[hdl/pese_ctrl.sv]
module pese_ctrl #(
  parameter int StackDepth = pese_pkg::DefStackDepth
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    symbol,
  input  logic                          first,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [$clog2(StackDepth+1)-1:0] count,
  output pese_pkg::status_t             status,
  output pese_pkg::op_t                 op,
  output pese_pkg::dp_cmd_t             cmd,
  input  pese_pkg::dp_sts_t             sts,
  output logic                          we,
  output logic [$clog2(StackDepth)-1:0] waddr,
  output logic [31:0]                   wdata,
  output logic [$clog2(StackDepth)-1:0] raddr,
  input  logic [31:0]                   result
);
  import pese_pkg::*;

  localparam int CntW = $clog2(StackDepth + 1);
  localparam int AddrW = $clog2(StackDepth);

  state_t state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  status_t st_r, st_nxt;
  op_t op_r, op_nxt;
  logic [CntW-1:0] base_cnt;
  logic is_digit, is_op;
  op_t dec_op;

  assign base_cnt = first ? '0 : cnt_r;
  assign is_digit = (symbol >= SymZero) && (symbol <= SymNine);

  always_comb begin
    is_op = 1'b1;
    dec_op = OP_ADD;
    unique case (symbol)
      SymPlus:  dec_op = OP_ADD;
      SymMinus: dec_op = OP_SUB;
      SymMul:   dec_op = OP_MUL;
      SymDiv:   dec_op = OP_DIV;
      SymMod:   dec_op = OP_MOD;
      SymPow:   dec_op = OP_POW;
      default:  is_op = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      st_r <= ST_OK;
      op_r <= OP_ADD;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      st_r <= st_nxt;
      op_r <= op_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    st_nxt = st_r;
    op_nxt = op_r;
    cmd = '0;
    we = 1'b0;
    waddr = '0;
    wdata = result;
    raddr = '0;
    in_tready = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cnt_nxt = base_cnt;
          st_nxt = ST_OK;
          op_nxt = dec_op;
          if (is_digit) begin
            if (base_cnt >= CntW'(StackDepth)) begin
              st_nxt = ST_OVERFLOW;
              state_nxt = S_RDTOP;
            end else begin
              we = 1'b1;
              waddr = base_cnt[AddrW-1:0];
              wdata = 32'(symbol - SymZero);
              cnt_nxt = base_cnt + CntW'(1);
              state_nxt = S_RDTOP;
            end
          end else if (is_op) begin
            if (base_cnt < CntW'(2)) begin
              st_nxt = ST_UNDERFLOW;
              state_nxt = S_RDTOP;
            end else begin
              raddr = AddrW'(base_cnt - CntW'(1));
              state_nxt = S_RDA;
            end
          end else begin
            st_nxt = ST_UNKNOWN;
            state_nxt = S_RDTOP;
          end
        end
      end
      S_RDA: begin
        cmd.load_a = 1'b1;
        raddr = AddrW'(cnt_r - CntW'(2));
        state_nxt = S_RDB;
      end
      S_RDB: begin
        raddr = AddrW'(cnt_r - CntW'(2));
        state_nxt = S_WAITB;
      end
      S_WAITB: begin
        cmd.load_b = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if ((op_r == OP_DIV || op_r == OP_MOD) && sts.b_zero) begin
          st_nxt = ST_DIVZERO;
          state_nxt = S_RDTOP;
        end else if (op_r == OP_DIV || op_r == OP_MOD || op_r == OP_POW) begin
          cmd.start_iter = 1'b1;
          state_nxt = S_ITER;
        end else begin
          cmd.exec_simple = 1'b1;
          state_nxt = S_WRITE;
        end
      end
      S_ITER: begin
        if (sts.iter_done) begin
          state_nxt = S_WRITE;
        end else begin
          cmd.step_iter = 1'b1;
        end
      end
      S_WRITE: begin
        we = 1'b1;
        waddr = AddrW'(cnt_r - CntW'(2));
        cnt_nxt = cnt_r - CntW'(1);
        state_nxt = S_RDTOP;
      end
      S_RDTOP: begin
        raddr = AddrW'(cnt_r - CntW'(1));
        state_nxt = S_TOPW;
      end
      S_TOPW: begin
        state_nxt = S_OUT;
        cmd.load_top = 1'b1;
      end
      S_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign count = cnt_r;
  assign status = st_r;
  assign op = op_r;
endmodule

[hdl/prefix_expression_stack_evaluator_unit.sv]
// Digits and status-only words skip the datapath; a division by zero stops after the operands
// are read; + - * compute directly, and / and % use a restoring divider that takes one
// quotient bit a cycle. Power runs one square-and-multiply step per exponent bit (up to 31).
// One word at a time: no new symbol is taken until the result word has been accepted.
// Synchronous active-low reset empties the stack; stack RAM is not cleared.
module prefix_expression_stack_evaluator_unit #(
  parameter int StackDepth = pese_pkg::DefStackDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // symbol[7:0]
  input  logic        in_tuser,   // first
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // top_value[31:0], depth[39:32], status[42:40], zero
);
  import pese_pkg::*;

  localparam int AddrW = $clog2(StackDepth);
  localparam int CntW = $clog2(StackDepth + 1);

  logic [CntW-1:0] count;
  status_t status;
  op_t op;
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic we;
  logic [AddrW-1:0] waddr, raddr;
  logic [31:0] wdata, rdata, result, top;
  logic [7:0] depth;

  pese_ram #(.Width(DataW), .Depth(StackDepth)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  pese_ctrl #(.StackDepth(StackDepth)) u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready,
    .symbol(in_tdata), .first(in_tuser),
    .out_tvalid, .out_tready, .count, .status, .op, .cmd, .sts,
    .we, .waddr, .wdata, .raddr, .result
  );

  pese_datapath u_dp (
    .clk, .op, .cmd, .rdata, .sts, .result, .top
  );

  assign depth = 8'(count);
  assign out_tdata = {5'd0, status, depth, (count == '0) ? 32'd0 : top};
endmodule

[dv/tb.sv]
module tb;
  import pese_pkg::*;

  localparam int Depth = DefStackDepth;
  localparam int LimitCycles = 2000000;

  typedef struct {
    logic [31:0] top_value;
    logic [7:0]  depth;
    status_t     status;
  } eval_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;

  logic [31:0]  model_stack [Depth];
  int unsigned  model_count;
  eval_result_t expected_results [$];
  int           fail_count = 0;
  int           cycle_count = 0;
  int           hold_off_cycles = 0;
  bit           stall_enable = 1'b1;

  prefix_expression_stack_evaluator_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LimitCycles) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  function automatic logic [31:0] power_mod(logic [31:0] base, logic [31:0] expo);
    logic [31:0] acc;
    acc = 32'd1;
    if ($signed(expo) <= 0) return 32'd1;
    while (expo != 0) begin
      if (expo[0]) acc = acc * base;
      base = base * base;
      expo = expo >> 1;
    end
    return acc;
  endfunction

  function automatic eval_result_t evaluate_symbol(logic [7:0] sym, logic first);
    eval_result_t res;
    logic [31:0] a, b, r;
    res.status = ST_OK;
    if (first) model_count = 0;
    if (sym >= SymZero && sym <= SymNine) begin
      if (model_count >= Depth) res.status = ST_OVERFLOW;
      else begin
        model_stack[model_count] = 32'(sym - SymZero);
        model_count++;
      end
    end else if (sym == SymPlus || sym == SymMinus || sym == SymMul ||
                 sym == SymDiv || sym == SymMod || sym == SymPow) begin
      if (model_count < 2) res.status = ST_UNDERFLOW;
      else begin
        a = model_stack[model_count-1];
        b = model_stack[model_count-2];
        if ((sym == SymDiv || sym == SymMod) && b == 0) res.status = ST_DIVZERO;
        else begin
          case (sym)
            SymPlus:  r = a + b;
            SymMinus: r = a - b;
            SymMul:   r = a * b;
            SymDiv:   r = 32'(longint'($signed(a)) / longint'($signed(b)));
            SymMod:   r = 32'(longint'($signed(a)) % longint'($signed(b)));
            default:  r = power_mod(a, b);
          endcase
          model_count--;
          model_stack[model_count-1] = r;
        end
      end
    end else res.status = ST_UNKNOWN;
    res.top_value = model_count != 0 ? model_stack[model_count-1] : 32'd0;
    res.depth = 8'(model_count);
    return res;
  endfunction

  task automatic send_symbol(logic [7:0] sym, logic first);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= sym;
    in_tuser  <= first;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_results.push_back(evaluate_symbol(sym, first));
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_tready <= 1'b0;
    end else if (!stall_enable) out_tready <= 1'b1;
    else if ($urandom_range(0, 29) == 0) begin
      hold_off_cycles <= $urandom_range(10, 40);
      out_tready <= 1'b0;
    end else out_tready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    eval_result_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected word %h", $time, out_tdata);
        fail_count++;
      end else begin
        exp_res = expected_results.pop_front();
        if (out_tdata[31:0] !== exp_res.top_value || out_tdata[39:32] !== exp_res.depth ||
            out_tdata[42:40] !== exp_res.status || out_tdata[47:43] !== '0) begin
          $display("%0t: expected top %h depth %0d status %0d, got top %h depth %0d status %0d",
                   $time, exp_res.top_value, exp_res.depth, exp_res.status,
                   out_tdata[31:0], out_tdata[39:32], out_tdata[42:40]);
          fail_count++;
        end
      end
    end
  end

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(0, 5))
      0: return SymPlus;
      1: return SymMinus;
      2: return SymMul;
      3: return SymDiv;
      4: return SymMod;
      default: return SymPow;
    endcase
  endfunction

  function automatic logic [7:0] pick_digit();
    return 8'(SymZero + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] SymSeven();
    return 8'(SymZero + 7);
  endfunction

  task automatic test_directed();
    send_symbol(SymPlus, 1'b1);
    send_symbol(SymZero, 1'b0);
    send_symbol(SymPlus, 1'b0);
    send_symbol(SymNine, 1'b0);
    send_symbol(SymDiv, 1'b0);
    send_symbol(SymMod, 1'b0);
    send_symbol(8'h00, 1'b0);
    send_symbol(8'hFF, 1'b0);
    send_symbol(SymSeven(), 1'b1);
    send_symbol(SymPow, 1'b0);
    send_symbol(SymMinus, 1'b0);
    send_symbol(SymZero, 1'b0);
    send_symbol(SymMinus, 1'b0);
    send_symbol(SymNine, 1'b0);
    send_symbol(SymMul, 1'b0);
    send_symbol(8'(SymZero + 3), 1'b0);
    send_symbol(SymDiv, 1'b0);
    send_symbol(SymMod, 1'b0);
    send_symbol(8'h55, 1'b0);
  endtask

  task automatic test_min_quotient();
    // A value built by add, power and subtract steps, divided by minus one.
    send_symbol(8'(SymZero + 1), 1'b1);
    send_symbol(SymZero, 1'b0);
    send_symbol(SymMinus, 1'b0);
    send_symbol(8'(SymZero + 2), 1'b0);
    send_symbol(8'(SymZero + 1), 1'b0);
    send_symbol(SymNine, 1'b0);
    send_symbol(SymNine, 1'b0);
    send_symbol(SymPlus, 1'b0);
    send_symbol(8'(SymZero + 3), 1'b0);
    send_symbol(SymPlus, 1'b0);
    send_symbol(SymPow, 1'b0);
    send_symbol(SymMinus, 1'b0);
    send_symbol(SymDiv, 1'b0);
    send_symbol(SymZero, 1'b1);
  endtask

  task automatic test_overflow();
    // The receiver holds off at first, then the stack is filled past its top.
    in_tvalid <= 1'b0;
    @(posedge clk);
    hold_off_cycles = 300;
    @(negedge clk);
    for (int i = 0; i < Depth + 4; i++) send_symbol(pick_digit(), i == 0);
    send_symbol(SymMul, 1'b0);
    send_symbol(SymNine, 1'b0);
  endtask

  task automatic test_random(int count);
    int sent;
    int len;
    sent = 0;
    while (sent < count) begin
      len = $urandom_range(1, 12);
      send_symbol(pick_digit(), 1'b1);
      sent++;
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 19) == 0) send_symbol(8'($urandom), 1'b0);
        else if ($urandom_range(0, 2) == 0) send_symbol(pick_operator(), 1'b0);
        else send_symbol(pick_digit(), $urandom_range(0, 40) == 0);
        sent++;
      end
      while (model_count > 1 && sent < count) begin
        send_symbol(pick_operator(), 1'b0);
        sent++;
      end
      if ($urandom_range(0, 15) == 0) stall_enable = ~stall_enable;
    end
    stall_enable = 1'b1;
  endtask

  initial begin
    int wait_cycles;
    model_count = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_min_quotient();
    test_overflow();
    test_random(1400);
    in_tvalid <= 1'b0;
    wait_cycles = 0;
    while (expected_results.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (60) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule
